// File: rtl/core/pdfs_pkg.sv
// ----------------------------------------------------------------------------
// pdfs_pkg
// Shared types, character codes and helpers for the percent decoder with
// field split.
// ----------------------------------------------------------------------------
package pdfs_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_BAR     = 8'h7C;  // '|'
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF      = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA      = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF      = 8'h46;  // 'F'

  localparam int MaxResults = 4;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_LINE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PEND_NONE    = 2'd0,
    PEND_PERCENT = 2'd1,
    PEND_DIGIT   = 2'd2
  } pend_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } entry_t;

  // One accepted input item's worth of results.
  typedef struct packed {
    logic [2:0]            count;
    entry_t [MaxResults-1:0] ent;
  } job_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_LA && c <= CH_LF) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  function automatic job_t add_entry(input job_t j, input kind_t k, input logic [7:0] b);
    job_t r;
    r = j;
    r.ent[j.count[1:0]].kind = k;
    r.ent[j.count[1:0]].data = (k == KIND_BYTE) ? b : 8'd0;
    r.count = j.count + 3'd1;
    return r;
  endfunction

endpackage

// File: rtl/core/pdfs_front.sv
// ----------------------------------------------------------------------------
// pdfs_front
// Accepts input beats, tracks escape state and builds the result list of
// each beat combinationally.
// ----------------------------------------------------------------------------
module pdfs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            has_byte,
  input  logic [7:0]      in_byte,
  input  logic            end_of_line,
  input  logic            q_full,
  output logic            push,
  output pdfs_pkg::job_t  job
);

  pdfs_pkg::pend_t pending, pending_next;
  logic [7:0]      held, held_next;
  logic            accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (job.count != 3'd0);

  always_comb begin
    logic [4:0] hb;
    logic [4:0] hh;
    pdfs_pkg::job_t j;
    pdfs_pkg::pend_t pc;
    logic [7:0] hd;
    logic replay;
    hb = pdfs_pkg::hex_decode(in_byte);
    hh = pdfs_pkg::hex_decode(held);
    j = '0;
    pc = pending;
    hd = held;
    replay = 1'b0;
    if (has_byte) begin
      if (in_byte == pdfs_pkg::CH_BAR) begin
        if (pc == pdfs_pkg::PEND_PERCENT || pc == pdfs_pkg::PEND_DIGIT) begin
          j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, pdfs_pkg::CH_PERCENT);
        end
        if (pc == pdfs_pkg::PEND_DIGIT) begin
          j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, hd);
        end
        pc = pdfs_pkg::PEND_NONE;
        hd = 8'd0;
        j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_FIELD, 8'd0);
      end else if (pc == pdfs_pkg::PEND_PERCENT) begin
        if (hb[4]) begin
          hd = in_byte;
          pc = pdfs_pkg::PEND_DIGIT;
        end else begin
          j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, pdfs_pkg::CH_PERCENT);
          replay = 1'b1;
        end
      end else if (pc == pdfs_pkg::PEND_DIGIT) begin
        if (hh[4] && hb[4]) begin
          j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, {hh[3:0], hb[3:0]});
          pc = pdfs_pkg::PEND_NONE;
          hd = 8'd0;
        end else begin
          j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, pdfs_pkg::CH_PERCENT);
          j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, hd);
          hd = 8'd0;
          replay = 1'b1;
        end
      end else begin
        replay = 1'b1;
      end
      // byte handled with no escape open
      if (replay) begin
        if (in_byte == pdfs_pkg::CH_PERCENT) begin
          pc = pdfs_pkg::PEND_PERCENT;
        end else begin
          pc = pdfs_pkg::PEND_NONE;
          j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, in_byte);
        end
      end
    end
    if (end_of_line) begin
      if (pc == pdfs_pkg::PEND_PERCENT || pc == pdfs_pkg::PEND_DIGIT) begin
        j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, pdfs_pkg::CH_PERCENT);
      end
      if (pc == pdfs_pkg::PEND_DIGIT) begin
        j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_BYTE, hd);
      end
      pc = pdfs_pkg::PEND_NONE;
      hd = 8'd0;
      j = pdfs_pkg::add_entry(j, pdfs_pkg::KIND_LINE, 8'd0);
    end
    job = j;
    pending_next = pc;
    held_next = hd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= pdfs_pkg::PEND_NONE;
      held    <= 8'd0;
    end else if (accept) begin
      pending <= pending_next;
      held    <= held_next;
    end
  end

`ifndef ASSERT_OFF
  a_pend_legal: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("pdfs_front: illegal escape state");
  a_held_hex: assert property (@(posedge clk) disable iff (rst)
    pending == pdfs_pkg::PEND_DIGIT |-> pdfs_pkg::hex_decode(held) >= 5'h10)
    else $error("pdfs_front: held digit is not hex");
`endif

endmodule

// File: rtl/core/pdfs_queue.sv
// ----------------------------------------------------------------------------
// pdfs_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module pdfs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pdfs_pkg::job_t  push_job,
  output logic            full,
  output logic            q_valid,
  output pdfs_pkg::job_t  q_job,
  input  logic            pop
);

  localparam int PtrW = $clog2(pdfs_pkg::QueueDepth);
  localparam int CntW = $clog2(pdfs_pkg::QueueDepth + 1);

  pdfs_pkg::job_t slots [pdfs_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(pdfs_pkg::QueueDepth));
  assign q_valid = (count != '0);
  assign q_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(pdfs_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(pdfs_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("pdfs_queue: push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pdfs_queue: pop while empty");
`endif

endmodule

// File: rtl/core/pdfs_back.sv
// ----------------------------------------------------------------------------
// pdfs_back
// Holds one job and plays its results out, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module pdfs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  pdfs_pkg::job_t  q_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  pdfs_pkg::job_t cur;
  logic           busy;
  logic [1:0]     idx;
  logic           out_accept;
  logic           at_last;

  assign at_last     = ({1'b0, idx} == cur.count - 3'd1);
  assign out_valid   = busy;
  assign out_accept  = busy && !out_stall;
  assign pop         = q_valid && (!busy || (out_accept && at_last));
  assign kind        = cur.ent[idx].kind;
  assign out_byte    = cur.ent[idx].data;
  assign last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (out_accept) begin
      if (at_last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, idx} < cur.count))
    else $error("pdfs_back: result index past job end");
`endif

endmodule

// File: rtl/core/percent_decoder_field_split_core.sv
// ----------------------------------------------------------------------------
// percent_decoder_field_split_core
// Percent decoder with '|' field split, one encoded byte per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat carries has_byte, in_byte
//   and end_of_line. A beat with has_byte low and end_of_line high closes the
//   line; one with both low is taken and produces nothing.
//   Output channel (out_valid / out_stall): each beat is one result: a
//   decoded byte (kind 0), a field end (kind 1) or a field end that also
//   ends the line (kind 2). last_of_run marks the final result of an input.
//   Path: the queue registers the result list of an input beat at accept,
//   the back then loads it into its job register, and the first result is
//   driven from that register.
//   Throughput: one input beat per cycle while the receiver does not stall
//   and every beat gives at most one result; a beat gives up to 4 results
//   on a broken escape at a line end. The output port (one result per
//   cycle) sets the sustained rate.
//   A two-entry job queue decouples the sides: in_stall rises only when it
//   is full, so a stalled receiver backs up into the queue, then the input.
//   Reset (rst, synchronous) clears the escape state, the queue and the
//   output; no clearing pass, inputs are taken the cycle after reset.
// ----------------------------------------------------------------------------
module percent_decoder_field_split_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       has_byte,
  input  logic [7:0] in_byte,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  // front -> queue
  logic           push;
  pdfs_pkg::job_t push_job;
  logic           q_full;

  // queue -> back
  logic           q_valid;
  pdfs_pkg::job_t q_job;
  logic           pop;

  // Front: escape tracking, builds up to four results per beat.
  pdfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .has_byte    (has_byte),
    .in_byte     (in_byte),
    .end_of_line (end_of_line),
    .q_full      (q_full),
    .push        (push),
    .job         (push_job)
  );

  // Beats with no results never enter the queue.
  pdfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop)
  );

  // Back: serializes one job; loads the next in the cycle its last beat goes.
  pdfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the percent decoder with field split. Directed
// beats cover byte extremes, good and broken escapes, field and line ends
// and marker-only beats. Random encoded lines and noise follow. Both
// channels idle at random. Each accepted result is checked against a local
// decoder kept in step with the accepted input beats.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 200;
  localparam int DrainCycles = 16;

  typedef struct {
    pdfs_pkg::kind_t kind;
    logic [7:0]      data;
    logic            last;
  } result_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic       has_byte    = 1'b0;
  logic [7:0] in_byte     = 8'd0;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  // Local decoder state, mirrors the escape tracking of the block.
  pdfs_pkg::pend_t pend_st  = pdfs_pkg::PEND_NONE;
  logic [7:0]      held_dig = 8'd0;

  result_t beat_results[$];   // results of the beat being decoded
  result_t decoded_q[$];      // results still owed by the block
  result_t want;

  int  err_cnt   = 0;
  int  item_cnt  = 0;         // beats that carry a byte or a line end
  int  cycle_cnt = 0;
  bit  quiet     = 1'b0;      // no idling on either side while set

  percent_decoder_field_split_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .has_byte    (has_byte),
    .in_byte     (in_byte),
    .end_of_line (end_of_line),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local decoder
  // --------------------------------------------------------------------------
  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= pdfs_pkg::CH_0 && c <= pdfs_pkg::CH_9) return int'(c - pdfs_pkg::CH_0);
    if (c >= pdfs_pkg::CH_LA && c <= pdfs_pkg::CH_LF) return 10 + int'(c - pdfs_pkg::CH_LA);
    if (c >= pdfs_pkg::CH_UA && c <= pdfs_pkg::CH_UF) return 10 + int'(c - pdfs_pkg::CH_UA);
    return -1;
  endfunction

  task automatic emit_result(input pdfs_pkg::kind_t k, input logic [7:0] d);
    result_t r;
    r.kind = k;
    r.data = (k == pdfs_pkg::KIND_BYTE) ? d : 8'd0;
    r.last = 1'b0;
    beat_results = {beat_results, r};
  endtask

  // Pending escape bytes come back out as literals.
  task automatic flush_escape();
    if (pend_st == pdfs_pkg::PEND_PERCENT) begin
      emit_result(pdfs_pkg::KIND_BYTE, pdfs_pkg::CH_PERCENT);
    end else if (pend_st == pdfs_pkg::PEND_DIGIT) begin
      emit_result(pdfs_pkg::KIND_BYTE, pdfs_pkg::CH_PERCENT);
      emit_result(pdfs_pkg::KIND_BYTE, held_dig);
    end
    pend_st  = pdfs_pkg::PEND_NONE;
    held_dig = 8'd0;
  endtask

  // Byte seen with no escape open: '%' opens one, anything else passes.
  task automatic take_plain(input logic [7:0] b);
    if (b == pdfs_pkg::CH_PERCENT) begin
      pend_st = pdfs_pkg::PEND_PERCENT;
    end else begin
      emit_result(pdfs_pkg::KIND_BYTE, b);
    end
  endtask

  task automatic decode_beat(input logic hb, input logic [7:0] b, input logic eol);
    int         hi;
    int         lo;
    logic [7:0] val;
    result_t    r;
    beat_results.delete();
    if (hb) begin
      if (b == pdfs_pkg::CH_BAR) begin
        flush_escape();
        emit_result(pdfs_pkg::KIND_FIELD, 8'd0);
      end else if (pend_st == pdfs_pkg::PEND_PERCENT) begin
        if (hex_digit_value(b) >= 0) begin
          held_dig = b;
          pend_st  = pdfs_pkg::PEND_DIGIT;
        end else begin
          // broken right after '%': give '%' back, rescan this byte
          emit_result(pdfs_pkg::KIND_BYTE, pdfs_pkg::CH_PERCENT);
          pend_st = pdfs_pkg::PEND_NONE;
          take_plain(b);
        end
      end else if (pend_st == pdfs_pkg::PEND_DIGIT) begin
        hi = hex_digit_value(held_dig);
        lo = hex_digit_value(b);
        if (hi >= 0 && lo >= 0) begin
          val = {hi[3:0], lo[3:0]};
          emit_result(pdfs_pkg::KIND_BYTE, val);
          pend_st  = pdfs_pkg::PEND_NONE;
          held_dig = 8'd0;
        end else begin
          // broken after one digit: '%' and the digit as literals
          emit_result(pdfs_pkg::KIND_BYTE, pdfs_pkg::CH_PERCENT);
          emit_result(pdfs_pkg::KIND_BYTE, held_dig);
          pend_st  = pdfs_pkg::PEND_NONE;
          held_dig = 8'd0;
          take_plain(b);
        end
      end else begin
        pend_st = pdfs_pkg::PEND_NONE;
        take_plain(b);
      end
    end
    if (eol) begin
      flush_escape();
      emit_result(pdfs_pkg::KIND_LINE, 8'd0);
    end
    foreach (beat_results[i]) begin
      r         = beat_results[i];
      r.last    = (i == beat_results.size() - 1);
      decoded_q = {decoded_q, r};
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on each input beat taken, then check the output beat.
  // Both in one process so same-edge ordering cannot matter.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_beat(has_byte, in_byte, end_of_line);
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected result: kind %0d byte %h last %0d",
                     kind, out_byte, last_of_run);
          end
        end else begin
          want = decoded_q.pop_front();
          if (kind !== want.kind || out_byte !== want.data ||
              last_of_run !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: expected kind %0d byte %h last %0d",
                       want.kind, want.data, want.last,
                       ", got kind %0d byte %h last %0d",
                       kind, out_byte, last_of_run);
            end
          end
        end
      end
      // receiver backpressure, stall chance about 30 percent unless quiet
      out_stall <= !quiet && ($urandom_range(99) < 30);
    end
  end

  // Hard stop on a hang.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Drive one beat and hold it until taken. Returns at the accepting edge with
  // valid still high; the next call or a drain decides what valid does next.
  task automatic send_item(input logic hb, input logic [7:0] b, input logic eol);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    has_byte    <= hb;
    in_byte     <= b;
    end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    if (hb || eol) item_cnt++;
  endtask

  // Sender holds off until the block owes nothing. It first lets the
  // monitor predict the last beat taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(2))
      0:       return pdfs_pkg::CH_0 + 8'($urandom_range(9));
      1:       return pdfs_pkg::CH_LA + 8'($urandom_range(5));
      default: return pdfs_pkg::CH_UA + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] rand_plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == pdfs_pkg::CH_PERCENT || c == pdfs_pkg::CH_BAR);
    return c;
  endfunction

  // Breaks an escape; may be '%', which reopens one.
  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (hex_digit_value(c) >= 0 || c == pdfs_pkg::CH_BAR);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_byte_extremes();
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1);
  endtask

  // Both cases of digits; the last escape completes on the line's last byte.
  task automatic test_good_escapes();
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b0);
    send_item(1'b1, "0", 1'b0);
    send_item(1'b1, "0", 1'b0);
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b0);
    send_item(1'b1, "f", 1'b0);
    send_item(1'b1, "F", 1'b1);
  endtask

  task automatic test_broken_escapes();
    // non-hex after '%'
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b0);
    send_item(1'b1, "G", 1'b0);
    // '%' after one digit reopens an escape, which then completes
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b0);
    send_item(1'b1, "7", 1'b0);
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b0);
    send_item(1'b1, "4", 1'b0);
    send_item(1'b1, "1", 1'b0);
    // field end with '%' open, then with '%' and a digit open
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b0);
    send_item(1'b1, pdfs_pkg::CH_BAR, 1'b0);
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b0);
    send_item(1'b1, "3", 1'b0);
    send_item(1'b1, pdfs_pkg::CH_BAR, 1'b0);
  endtask

  task automatic test_line_ends();
    // '%' itself on the line end: flushed at once
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b1);
    // '%5' then '|' ending the line: four results from one beat
    send_item(1'b1, pdfs_pkg::CH_PERCENT, 1'b0);
    send_item(1'b1, "5", 1'b0);
    send_item(1'b1, pdfs_pkg::CH_BAR, 1'b1);
    // empty line, then a beat with nothing in it
    send_item(1'b0, 8'h5A, 1'b1);
    send_item(1'b0, 8'hA5, 1'b0);
  endtask

  // One encoded line of 1..4 fields built from random chunks.
  task automatic send_random_line();
    logic [7:0] line_q[$];
    int         nf;
    int         nc;
    int         pick;
    bit         eol_on_byte;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      nc = $urandom_range(0, 4);
      for (int c = 0; c < nc; c++) begin
        pick = $urandom_range(0, 11);
        if (pick < 4) begin
          line_q = {line_q, rand_plain_char()};
        end else if (pick < 8) begin
          line_q = {line_q, pdfs_pkg::CH_PERCENT};
          line_q = {line_q, rand_hex_char()};
          line_q = {line_q, rand_hex_char()};
        end else if (pick == 8) begin
          line_q = {line_q, pdfs_pkg::CH_PERCENT};
          line_q = {line_q, rand_non_hex()};
        end else if (pick == 9) begin
          line_q = {line_q, pdfs_pkg::CH_PERCENT};
          line_q = {line_q, rand_hex_char()};
          line_q = {line_q, rand_non_hex()};
        end else if (pick == 10) begin
          line_q = {line_q, pdfs_pkg::CH_PERCENT};
        end else begin
          line_q = {line_q, pdfs_pkg::CH_PERCENT};
          line_q = {line_q, rand_hex_char()};
        end
      end
      // separator between fields, sometimes a trailing one too
      if (f < nf - 1 || $urandom_range(3) == 0) line_q = {line_q, pdfs_pkg::CH_BAR};
    end
    eol_on_byte = (line_q.size() > 0) && ($urandom_range(1) == 1);
    foreach (line_q[i]) begin
      send_item(1'b1, line_q[i], eol_on_byte && (i == line_q.size() - 1));
    end
    if (!eol_on_byte) send_item(1'b0, 8'($urandom_range(255)), 1'b1);
  endtask

  // Unstructured beats: any byte, stray line ends, empty beats.
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_item($urandom_range(99) < 85, 8'($urandom_range(255)),
                $urandom_range(99) < 10);
    end
  endtask

  task automatic test_random_traffic();
    int start;
    start = item_cnt;
    while (item_cnt < start + RandomItems) begin
      // a stretch in the middle with no idling on either side
      quiet = (item_cnt >= start + 70) && (item_cnt < start + 130);
      if ($urandom_range(99) < 80) begin
        send_random_line();
      end else begin
        send_noise($urandom_range(1, 4));
      end
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_byte_extremes();
    test_good_escapes();
    test_broken_escapes();
    test_line_ends();
    wait_for_results();
    test_random_traffic();
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $display("missing results: %0d", decoded_q.size());
    end
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
